FILE: src/fms_pkg.sv
package fms_pkg;

   // Field widths of the request and response beats
   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 10;
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 6;

   // Operation codes
   typedef logic [FUNC_W-1:0] func_type;
   localparam func_type FUNC_RECORD = 2'd0;
   localparam func_type FUNC_QUERY  = 2'd1;
   localparam func_type FUNC_MERGE  = 2'd2;

   typedef logic [WORD_W-1:0] word_type;

   // MurmurHash3 x86_32 constants for a single 4-byte block
   localparam word_type MUR_C1    = 32'hcc9e_2d51;
   localparam word_type MUR_C2    = 32'h1b87_3593;
   localparam word_type MUR_N     = 32'he654_6b64;
   localparam word_type MUR_FMIX1 = 32'h85eb_ca6b;
   localparam word_type MUR_FMIX2 = 32'hc2b2_ae35;
   localparam word_type MUR_LEN   = 32'd4;
   localparam int       MUR_R1    = 15;
   localparam int       MUR_R2    = 13;

   // Bit set when the hash is zero (trailing-zero count taken as 31)
   localparam word_type ZERO_HASH_BIT = 32'h8000_0000;

   // Rotate left by a constant amount
   function automatic word_type rotl32(word_type x, int r);
      return (x << r) | (x >> (WORD_W - r));
   endfunction

endpackage

FILE: src/fms_req_if.sv
interface fms_req_if;
   logic                            valid;
   logic                            ready;
   fms_pkg::func_type               func;
   logic [fms_pkg::INDEX_W-1:0]     reg_index;
   fms_pkg::word_type               element;
   fms_pkg::word_type               merge_mask;

   modport source (output valid, func, reg_index, element, merge_mask, input ready);
   modport sink   (input valid, func, reg_index, element, merge_mask, output ready);
endinterface

FILE: src/fms_rsp_if.sv
interface fms_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [fms_pkg::COUNT_W-1:0]     zero_count;
   fms_pkg::word_type               reg_value;

   modport source (output valid, zero_count, reg_value, input ready);
   modport sink   (input valid, zero_count, reg_value, output ready);
endinterface

FILE: src/fms_ram.sv
module fms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/fms_hash.sv
module fms_hash (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  fms_pkg::word_type key,
   input  fms_pkg::word_type seed,
   output logic              out_valid,
   output fms_pkg::word_type set_bit
);

   localparam int STAGES = 5;

   logic [STAGES-1:0] vld_ff, vld_in;
   fms_pkg::word_type s1_ff, s1_in;
   fms_pkg::word_type s2_ff, s2_in;
   fms_pkg::word_type s3_ff, s3_in;
   fms_pkg::word_type s4_ff, s4_in;
   fms_pkg::word_type s5_ff, s5_in;
   fms_pkg::word_type mix_a, mix_b, mix_c, fold, hash, low_bit;

   // Advance the valid chain
   assign vld_in = {vld_ff[STAGES-2:0], in_valid};

   // Block mix: one multiply per stage
   assign s1_in = key * fms_pkg::MUR_C1;
   assign s2_in = fms_pkg::rotl32(s1_ff, fms_pkg::MUR_R1) * fms_pkg::MUR_C2;

   // Combine with seed, xor in the length, first fold of the finalizer
   always_comb begin
      mix_a = fms_pkg::rotl32(seed ^ s2_ff, fms_pkg::MUR_R2);
      mix_b = (mix_a + (mix_a << 2)) + fms_pkg::MUR_N;
      mix_c = mix_b ^ fms_pkg::MUR_LEN;
      s3_in = mix_c ^ (mix_c >> 16);
   end

   assign s4_in = s3_ff * fms_pkg::MUR_FMIX1;
   assign fold  = s4_ff ^ (s4_ff >> 13);
   assign s5_in = fold * fms_pkg::MUR_FMIX2;

   // Last fold, then isolate the lowest set bit
   assign hash    = s5_ff ^ (s5_ff >> 16);
   assign low_bit = hash & (~hash + fms_pkg::word_type'(1));
   assign set_bit = (hash == '0) ? fms_pkg::ZERO_HASH_BIT : low_bit;
   assign out_valid = vld_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      s5_ff <= s5_in;
   end

endmodule

FILE: src/fm_sketch_register_bank_core.sv
// Channel  Dir  Beat contents
// req_ch   in   func, reg_index, element, merge_mask
// rsp_ch   out  zero_count, reg_value
// csr      in   hash_seed write (csr_wr_en, csr_wr_data)
//
// One item at a time: query and merge go from the bank read to the update;
// record also waits in ST_HASH for the 5-stage hash pipeline before its update.
// After reset the bank is cleared one word per cycle across all NUM_REGS words;
// req_ch.ready stays low during that pass.
// A finished result waits in the output register; the next beat is taken
// meanwhile and its update holds until rsp_ch is free.
module fm_sketch_register_bank_core #(
   parameter int NUM_REGS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   fms_req_if.sink                    req_ch,
   fms_rsp_if.source                  rsp_ch,
   input  logic                       csr_wr_en,
   input  fms_pkg::word_type          csr_wr_data
);

   localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int IW = fms_pkg::INDEX_W;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_HASH, ST_UPDATE} state_type;

   state_type                    state_ff, state_in;
   logic [AW-1:0]                clr_addr_ff, clr_addr_in;
   fms_pkg::word_type            seed_ff, seed_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   fms_pkg::func_type            func_ff, func_in;
   logic                         hit_ff, hit_in;
   logic [AW-1:0]                addr_ff, addr_in;
   fms_pkg::word_type            mask_ff, mask_in;
   fms_pkg::word_type            bit_ff, bit_in;
   logic [fms_pkg::COUNT_W-1:0]  zero_count_ff, zero_count_in;
   fms_pkg::word_type            reg_value_ff, reg_value_in;

   logic                         accept, update_fire, hash_valid;
   logic [AW+IW-1:0]             idx_wide;
   logic [AW-1:0]                req_addr;
   logic                         req_hit;
   fms_pkg::word_type            set_bit, rd_data, new_val, wr_data;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;

   // Map the request index onto the RAM address
   assign idx_wide = {{AW{1'b0}}, req_ch.reg_index};
   assign req_addr = idx_wide[AW-1:0];
   assign req_hit  = 32'(req_ch.reg_index) < 32'(NUM_REGS);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign update_fire  = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ch.ready);

   fms_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && (req_ch.func == fms_pkg::FUNC_RECORD)),
      .key       (req_ch.element),
      .seed      (seed_ff),
      .out_valid (hash_valid),
      .set_bit   (set_bit)
   );

   fms_ram #(
      .WIDTH (fms_pkg::WORD_W),
      .DEPTH (NUM_REGS),
      .AW    (AW)
   ) u_bank (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_data)
   );

   // Modify the word read from the bank
   always_comb begin
      unique case (func_ff)
         fms_pkg::FUNC_RECORD: new_val = rd_data | bit_ff;
         fms_pkg::FUNC_MERGE:  new_val = rd_data | mask_ff;
         default:              new_val = rd_data;
      endcase
   end

   // Bank write: clearing pass or write-back
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = update_fire && hit_ff;
         wr_addr = addr_ff;
         wr_data = new_val;
      end
   end

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      seed_in       = csr_wr_en ? csr_wr_data : seed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      func_in       = func_ff;
      hit_in        = hit_ff;
      addr_in       = addr_ff;
      mask_in       = mask_ff;
      bit_in        = hash_valid ? set_bit : bit_ff;
      zero_count_in = zero_count_ff;
      reg_value_in  = reg_value_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(NUM_REGS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               func_in  = req_ch.func;
               hit_in   = req_hit;
               addr_in  = req_addr;
               mask_in  = req_ch.merge_mask;
               state_in = (req_ch.func == fms_pkg::FUNC_RECORD) ? ST_HASH : ST_UPDATE;
            end
         end
         ST_HASH: begin
            if (hash_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (update_fire) begin
               reg_value_in  = hit_ff ? new_val : '0;
               zero_count_in = fms_pkg::COUNT_W'(fms_pkg::WORD_W -
                                                 $countones(hit_ff ? new_val : '0));
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff       <= func_in;
      hit_ff        <= hit_in;
      addr_ff       <= addr_in;
      mask_ff       <= mask_in;
      bit_ff        <= bit_in;
      zero_count_ff <= zero_count_in;
      reg_value_ff  <= reg_value_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.zero_count = zero_count_ff;
   assign rsp_ch.reg_value  = reg_value_ff;

endmodule
